@@ design/poic_pkg.sv @@
// shared types and constants for the periodic overlap insertion check
package poic_pkg;

  localparam int MAX_SPHERES = 4096;
  localparam int COORD_BITS  = 24;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
  localparam int BOX_W       = 23;
  localparam int RAD_W       = 20;
  localparam int STATUS_W    = 2;

  localparam int DIFF_W = COORD_BITS + 3;
  localparam int MAG_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RS_W   = RAD_W + 1;
  localparam int RS2_W  = 2 * RS_W;

  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(4614144);

  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic        [RAD_W-1:0]      radius;
  } cand_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
    logic [CNT_W-1:0]    stored_count;
  } result_t;

endpackage

@@ design/periodic_overlap_insertion_check.sv @@
// Hard-sphere insertion check in a periodic cube: each candidate word is compared with
// every stored sphere by minimum-image distance and is stored when it overlaps none.
// One sphere is read from the store per cycle during the scan, so the single-port-read
// sphere store makes the time per item grow with fill_count; the scan ends early at the
// first overlap, and a full or empty store answers without a scan. One result word is
// returned per input word; the result register lets the next candidate start while a
// result waits.
module periodic_overlap_insertion_check
  import poic_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BOX_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  cand_t            in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  cand_t mem [MAX_SPHERES];

  logic [1:0]          state;
  logic [BOX_W-1:0]    box_length;
  logic [CNT_W-1:0]    fill_count;
  logic [CNT_W-1:0]    issue_cnt;
  logic [CNT_W-1:0]    res_cnt;
  logic [STATUS_W-1:0] res_status;
  cand_t               cand;
  cand_t               rd_data;
  logic                rd_valid;

  logic rd_en;
  logic wr_en;
  logic out_free;
  logic dist_valid;
  logic dist_hit;
  logic hit_evt;
  logic last_evt;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;
  assign hit_evt  = dist_valid && dist_hit;
  assign last_evt = dist_valid && !dist_hit && (res_cnt == fill_count - CNT_W'(1));
  assign rd_en    = (state == S_SCAN) && (issue_cnt < fill_count) && !hit_evt && !last_evt;
  assign wr_en    = (state == S_DONE) && out_free && (res_status == ST_ACCEPT);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[issue_cnt[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[fill_count[IDX_W-1:0]] <= cand;
    end
  end

  poic_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .flush       (hit_evt),
    .entry_valid (rd_valid),
    .entry       (rd_data),
    .cand        (cand),
    .box_length  (box_length),
    .hit_valid   (dist_valid),
    .hit         (dist_hit)
  );

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cand <= in_word;
    end
    if (state == S_DONE && out_free) begin
      out_word.status <= res_status;
      if (res_status == ST_ACCEPT) begin
        out_word.slot         <= fill_count[IDX_W-1:0];
        out_word.stored_count <= fill_count + CNT_W'(1);
      end else begin
        out_word.slot         <= '0;
        out_word.stored_count <= fill_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      box_length <= BOX_RESET;
      fill_count <= '0;
      issue_cnt  <= '0;
      res_cnt    <= '0;
      res_status <= ST_ACCEPT;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        box_length <= cfg_wdata;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rd_valid <= rd_en;
      if (rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (dist_valid) begin
        res_cnt <= res_cnt + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          issue_cnt <= '0;
          res_cnt   <= '0;
          if (in_valid) begin
            if (fill_count == CNT_W'(MAX_SPHERES)) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else if (fill_count == '0) begin
              res_status <= ST_ACCEPT;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit_evt) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else if (last_evt) begin
            res_status <= ST_ACCEPT;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (res_status == ST_ACCEPT) begin
              fill_count <= fill_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/poic_dist.sv @@
// pipelined minimum-image distance test of one stored sphere against the candidate
module poic_dist
  import poic_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             flush,
  input  logic             entry_valid,
  input  cand_t            entry,
  input  cand_t            cand,
  input  logic [BOX_W-1:0] box_length,
  output logic             hit_valid,
  output logic             hit
);

  function automatic logic [MAG_W-1:0] wrap_mag(input logic signed [COORD_BITS-1:0] s,
                                                input logic signed [COORD_BITS-1:0] c,
                                                input logic [BOX_W-1:0] len);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] d2;
    logic signed [DIFF_W-1:0] l;
    d  = DIFF_W'(s) - DIFF_W'(c);
    l  = $signed(DIFF_W'(len));
    d2 = d <<< 1;
    if (d2 >= l) begin
      d = d - l;
    end else if (d2 < -l) begin
      d = d + l;
    end
    return d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  logic             a_valid;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [MAG_W-1:0] mag_z;
  logic [RS_W-1:0]  rsum;

  logic             b_valid;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;
  logic [SQ_W-1:0]  sq_z;
  logic [RS2_W-1:0] rsum_sq;

  logic [SUM_W-1:0] dist_sq;

  assign dist_sq = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    mag_x   <= wrap_mag(entry.pos_x, cand.pos_x, box_length);
    mag_y   <= wrap_mag(entry.pos_y, cand.pos_y, box_length);
    mag_z   <= wrap_mag(entry.pos_z, cand.pos_z, box_length);
    rsum    <= RS_W'(entry.radius) + RS_W'(cand.radius);
    sq_x    <= mag_x * mag_x;
    sq_y    <= mag_y * mag_y;
    sq_z    <= mag_z * mag_z;
    rsum_sq <= rsum * rsum;
    hit     <= dist_sq < SUM_W'(rsum_sq);
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      a_valid   <= entry_valid;
      b_valid   <= a_valid;
      hit_valid <= b_valid;
    end
  end

endmodule

@@ design/poic_check.sv @@
// port-level checks for the periodic overlap insertion check, bound to the top level
module poic_check
  import poic_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_word
);

  property p_out_hold;
    @(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(out_word);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("stalled result word changed");

  property p_accept_busy;
    @(posedge clk) disable iff (rst)
      in_valid && !in_stall |=> in_stall;
  endproperty
  a_accept_busy: assert property (p_accept_busy) else $error("input open after a word was taken");

  property p_accept_slot;
    @(posedge clk) disable iff (rst)
      out_valid && out_word.status == ST_ACCEPT |->
        out_word.stored_count == CNT_W'(out_word.slot) + CNT_W'(1);
  endproperty
  a_accept_slot: assert property (p_accept_slot) else $error("slot and count disagree");

  property p_other_slot;
    @(posedge clk) disable iff (rst)
      out_valid && out_word.status != ST_ACCEPT |-> out_word.slot == '0;
  endproperty
  a_other_slot: assert property (p_other_slot) else $error("slot set on a refused word");

  property p_full_count;
    @(posedge clk) disable iff (rst)
      out_valid && out_word.status == ST_FULL |->
        out_word.stored_count == CNT_W'(MAX_SPHERES);
  endproperty
  a_full_count: assert property (p_full_count) else $error("full status below capacity");

endmodule

bind periodic_overlap_insertion_check poic_check u_poic_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

@@ tb/sv/periodic_overlap_insertion_check_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the periodic overlap insertion check with a scoreboard class

module periodic_overlap_insertion_check_test;
  import poic_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam longint COORD_MAX = 64'sd8388607;

  class insertion_scoreboard;
    longint  sx [MAX_SPHERES];
    longint  sy [MAX_SPHERES];
    longint  sz [MAX_SPHERES];
    longint  sr [MAX_SPHERES];
    int      fill;
    longint  box;
    result_t due_results[$];
    int      errors;

    function new();
      fill   = 0;
      box    = longint'(BOX_RESET);
      errors = 0;
    endfunction

    // squared minimum-image separation along one axis
    function longint unsigned axis_sq(longint held, longint cand);
      longint d;
      longint unsigned mag;
      d = held - cand;
      if (2 * d >= box) begin
        d = d - box;
      end else if (2 * d < -box) begin
        d = d + box;
      end
      mag = (d < 0) ? longint'(-d) : longint'(d);
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
      end
      return mag * mag;
    endfunction

    function void note_candidate(cand_t w);
      longint x, y, z, r;
      longint unsigned rs, dsq;
      result_t res;
      bit hit;
      int j;
      x = longint'($signed(w.pos_x));
      y = longint'($signed(w.pos_y));
      z = longint'($signed(w.pos_z));
      r = longint'(w.radius);
      res = '0;
      hit = 1'b0;
      if (fill >= MAX_SPHERES) begin
        res.status = ST_FULL;
      end else begin
        for (j = 0; j < fill && !hit; j++) begin
          rs  = r + sr[j];
          dsq = axis_sq(sx[j], x) + axis_sq(sy[j], y) + axis_sq(sz[j], z);
          if (dsq < rs * rs) begin
            hit = 1'b1;
          end
        end
        if (hit) begin
          res.status = ST_REJECT;
        end else begin
          res.status = ST_ACCEPT;
          res.slot   = IDX_W'(fill);
          sx[fill]   = x;
          sy[fill]   = y;
          sz[fill]   = z;
          sr[fill]   = r;
          fill++;
        end
      end
      res.stored_count = CNT_W'(fill);
      due_results = {due_results, res};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: status %0d slot %0d count %0d",
                 $time, got.status, got.slot, got.stored_count);
        return;
      end
      want = due_results.pop_front();
      if (got.status != want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.slot != want.slot) begin
        errors++;
        $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
      end
      if (got.stored_count != want.stored_count) begin
        errors++;
        $display("%0t: stored_count expected %0d, got %0d", $time, want.stored_count,
                 got.stored_count);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [BOX_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  cand_t            in_word;
  logic             out_valid;
  logic             out_stall;
  result_t          out_word;

  insertion_scoreboard sb;
  bit                  steady;
  bit                  hold_req;
  int unsigned         cycle_count = 0;

  periodic_overlap_insertion_check u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("periodic_overlap_insertion_check_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_candidate(in_word);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_word);
      end
    end
  end

  // result side: random stalls, rare long bursts, one long hold on request
  initial begin : sink
    int burst;
    int pick;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (steady) begin
        out_stall = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          burst = $urandom_range(20, 80);
          out_stall = 1'b1;
        end else begin
          out_stall = (pick < 25);
        end
      end
    end
  end

  function automatic cand_t mk_cand(longint x, longint y, longint z, longint r);
    cand_t c;
    c.pos_x  = x[COORD_BITS-1:0];
    c.pos_y  = y[COORD_BITS-1:0];
    c.pos_z  = z[COORD_BITS-1:0];
    c.radius = r[RAD_W-1:0];
    return c;
  endfunction

  function automatic int pick_gap();
    int pick;
    if (steady) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // mostly spheres inside the half box, some touching or crowding a stored one, some noise
  function automatic cand_t random_candidate();
    longint span, x, y, z, r, delta;
    int pick;
    int j;
    pick = $urandom_range(0, 99);
    span = sb.box;
    if (pick < 12 && sb.fill > 0) begin
      j = $urandom_range(0, sb.fill - 1);
      r = $urandom_range(0, 65536);
      delta = sb.sr[j] + r - $urandom_range(0, 1);
      x = sb.sx[j] + delta;
      if (x > COORD_MAX) begin
        x = sb.sx[j] - delta;
      end
      return mk_cand(x, sb.sy[j], sb.sz[j], r);
    end else if (pick < 30) begin
      r = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 65536);
      return mk_cand($urandom(), $urandom(), $urandom(), r);
    end
    x = longint'($urandom_range(0, span)) - span / 2;
    y = longint'($urandom_range(0, span)) - span / 2;
    z = longint'($urandom_range(0, span)) - span / 2;
    r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65536);
    return mk_cand(x, y, z, r);
  endfunction

  task automatic send_word(cand_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_box(logic [BOX_W-1:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.box = longint'(v);
  endtask

  initial begin : stimulus
    logic [BOX_W-1:0] phase_box [5];
    int p;
    int k;
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset box length: overlap, exact touch, wrap across the box edge
    send_word(mk_cand(0, 0, 0, 65536));
    send_word(mk_cand(0, 0, 0, 65536));
    send_word(mk_cand(131072, 0, 0, 65536));
    send_word(mk_cand(0, 131071, 0, 65536));
    send_word(mk_cand(2300000, 0, 0, 65536));
    send_word(mk_cand(-2300000, 0, 0, 65536));
    send_word(mk_cand(-2307072, 0, 0, 0));
    send_word(mk_cand(0, 2307072, 0, 0));
    send_word(mk_cand(-8388608, -8388608, -8388608, 0));
    send_word(mk_cand(8388607, 8388607, 8388607, 0));
    send_word(mk_cand(0, 0, 2000000, 20'hFFFFF));
    send_word(mk_cand(196608, 196608, 0, 0));
    send_word(mk_cand(196608, 196608, 0, 0));

    // zero box length, no wrap
    write_box('0);
    send_word(mk_cand(8388607, 8388607, 8388607, 1));
    send_word(mk_cand(-8388608, 8388607, 0, 0));

    write_box(BOX_W'(1));
    send_word(mk_cand(1, 0, 0, 0));

    write_box({BOX_W{1'b1}});
    send_word(mk_cand(-4194303, 0, -4194304, 65536));
    send_word(mk_cand(4194303, 0, -4194304, 65536));

    phase_box[0] = BOX_W'($urandom_range(1, 8388607));
    phase_box[1] = {BOX_W{1'b1}};
    phase_box[2] = BOX_W'(1);
    phase_box[3] = '0;
    phase_box[4] = BOX_RESET;
    for (p = 0; p < 5; p++) begin
      write_box(phase_box[p]);
      k = 0;
      if (p == 1) begin
        // long receiver hold while words keep coming
        steady   = 1'b1;
        hold_req = 1'b1;
        for (k = 0; k < 12; k++) begin
          send_word(random_candidate());
        end
        steady = 1'b0;
      end
      steady = (p == 3);
      for (; k < 24; k++) begin
        send_word(random_candidate());
      end
      steady = 1'b0;
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("periodic_overlap_insertion_check_test: PASS");
    end else begin
      $display("periodic_overlap_insertion_check_test: FAIL");
    end
    $finish;
  end

endmodule
